@@ sv/sss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the seven-segment scan block
// Opcodes, register indexes, reset values, the character font and the
// structs that pass configuration and results between modules.
// ----------------------------------------------------------------------------
package sss_pkg;

	// operation codes of an input transaction
	localparam logic [2:0] OP_WRITE_CHAR = 3'd0;
	localparam logic [2:0] OP_WRITE_RAW  = 3'd1;
	localparam logic [2:0] OP_CLEAR      = 3'd2;
	localparam logic [2:0] OP_SCAN       = 3'd3;
	localparam logic [2:0] OP_TIME       = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_ACTIVE_LEVEL     = 3'd0;
	localparam logic [2:0] CFG_TEST_ENABLE      = 3'd1;
	localparam logic [2:0] CFG_TEST_KIND        = 3'd2;
	localparam logic [2:0] CFG_TEST_FIRST_DIGIT = 3'd3;
	localparam logic [2:0] CFG_TEST_END_DIGIT   = 3'd4;
	localparam logic [2:0] CFG_BLANK_CODE       = 3'd5;
	localparam logic [2:0] CFG_ZERO_CODE        = 3'd6;
	localparam logic [2:0] CFG_TEST_PERIOD      = 3'd7;

	// register reset values
	localparam logic [3:0]  RST_END_DIGIT = 4'd8;
	localparam logic [7:0]  RST_ZERO_CODE = 8'b0111_1110;
	localparam logic [15:0] RST_PERIOD    = 16'd500;

	// self-test constants
	localparam logic [7:0] WALK_TOP       = 8'h80;
	localparam logic [3:0] FONT_LAST_STEP = 4'd9;
	localparam logic [3:0] WALK_LAST_STEP = 4'd7;
	localparam logic [7:0] LINES_IDLE     = 8'hFF;

	typedef struct packed {
		logic        active_level;
		logic        test_enable;
		logic        test_kind;
		logic [2:0]  test_first_digit;
		logic [3:0]  test_end_digit;
		logic [7:0]  blank_code;
		logic [7:0]  zero_code;
		logic [15:0] test_period;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0] digit_lines;
		logic [7:0] segments;
		logic       bad_code;
		logic [2:0] test_digit;
	} result_t;

	// character font; entries past the defined ones are blank
	function automatic logic [7:0] font_lookup(input logic [5:0] code);
		logic [7:0] seg;
		case (code)
			6'd0:  seg = 8'h7E;
			6'd1:  seg = 8'h30;
			6'd2:  seg = 8'h6D;
			6'd3:  seg = 8'h79;
			6'd4:  seg = 8'h33;
			6'd5:  seg = 8'h5B;
			6'd6:  seg = 8'h5F;
			6'd7:  seg = 8'h70;
			6'd8:  seg = 8'h7F;
			6'd9:  seg = 8'h7B;
			6'd10: seg = 8'h77;
			6'd11: seg = 8'h1F;
			6'd12: seg = 8'h4E;
			6'd13: seg = 8'h3D;
			6'd14: seg = 8'h4F;
			6'd15: seg = 8'h47;
			6'd16: seg = 8'h5E;
			6'd17: seg = 8'h17;
			6'd18: seg = 8'h10;
			6'd19: seg = 8'h38;
			6'd20: seg = 8'h2F;
			6'd21: seg = 8'h0E;
			6'd22: seg = 8'h76;
			6'd23: seg = 8'h15;
			6'd24: seg = 8'h1D;
			6'd25: seg = 8'h67;
			6'd26: seg = 8'h73;
			6'd27: seg = 8'h05;
			6'd28: seg = 8'h1B;
			6'd29: seg = 8'h0F;
			6'd30: seg = 8'h3E;
			6'd31: seg = 8'h1C;
			6'd32: seg = 8'h2B;
			6'd33: seg = 8'h36;
			6'd34: seg = 8'h3B;
			6'd35: seg = 8'h49;
			6'd36: seg = 8'h08;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

@@ sv/seven_segment_scan_with_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_with_test: multiplexed seven-segment driver with self-test
// Keeps an eight-digit segment buffer, scans it one digit per scan tick and
// can walk a font or single-segment test pattern across the digits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction:
//   write a font character, write raw segments, clear the buffer, scan
//   tick or time tick. Every accepted transaction yields exactly one result
//   transaction on the output channel (out_valid/out_ready) holding the
//   drive latch (digit_lines, segments), the bad_code flag and test_digit.
//   The result register loads a command's result at the edge that accepts it.
//   Throughput is one transaction per cycle while the receiver does not stall,
//   set by the single-stage state update in sss_core feeding the result register.
//   If the receiver stalls, the result register holds its transaction and
//   in_ready stays high only while that register is empty or being drained.
//   The configuration channel (cfg_valid/cfg_ready) is always ready and
//   writes one register per transaction; write it only while idle.
//   Reset clears the buffer to zero, parks the digit lines inactive (all
//   ones), zeroes the segments and loads the register defaults.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_test #(
	parameter int DIGITS       = 8,
	parameter int FONT_ENTRIES = 37
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [2:0]  digit_index,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  digit_lines,
	output logic [7:0]  segments,
	output logic        bad_code,
	output logic [2:0]  test_digit,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sss_pkg::*;

	cfg_t    cfg;
	cfg_wr_t cfg_wr;
	result_t result;
	result_t res_q;
	logic    out_valid_q;
	logic    in_fire;

	// config writes never stall
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// take a new command whenever the result slot is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	sss_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	sss_core #(
		.DIGITS       (DIGITS),
		.FONT_ENTRIES (FONT_ENTRIES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.opcode      (opcode),
		.digit_index (digit_index),
		.char_code   (char_code),
		.cfg         (cfg),
		.cfg_wr      (cfg_wr),
		.result      (result)
	);

	// result register: valid flag under reset, payload loads on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_lines = res_q.digit_lines;
	assign segments    = res_q.segments;
	assign bad_code    = res_q.bad_code;
	assign test_digit  = res_q.test_digit;

	// every accepted command produces a pending result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted command did not produce a result");

	// only a font write can flag a bad code
	a_bad_only_char: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && opcode != OP_WRITE_CHAR |=> !res_q.bad_code)
		else $error("bad_code raised by a non-font command");

	// a scan drives exactly one digit line at the active level
	a_scan_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && opcode == OP_SCAN |=>
			($countones(res_q.digit_lines) == 1 || $countones(res_q.digit_lines) == 7))
		else $error("scan did not select exactly one digit line");

endmodule

@@ sv/sss_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_regs: configuration register file
// Holds the eight control registers, written one at a time by index.
// ----------------------------------------------------------------------------
module sss_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  sss_pkg::cfg_wr_t cfg_wr,
	output sss_pkg::cfg_t    cfg
);
	import sss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level     <= 1'b0;
			cfg_q.test_enable      <= 1'b0;
			cfg_q.test_kind        <= 1'b0;
			cfg_q.test_first_digit <= 3'd0;
			cfg_q.test_end_digit   <= RST_END_DIGIT;
			cfg_q.blank_code       <= 8'd0;
			cfg_q.zero_code        <= RST_ZERO_CODE;
			cfg_q.test_period      <= RST_PERIOD;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				CFG_ACTIVE_LEVEL:     cfg_q.active_level     <= cfg_wr.data[0];
				CFG_TEST_ENABLE:      cfg_q.test_enable      <= cfg_wr.data[0];
				CFG_TEST_KIND:        cfg_q.test_kind        <= cfg_wr.data[0];
				CFG_TEST_FIRST_DIGIT: cfg_q.test_first_digit <= cfg_wr.data[2:0];
				CFG_TEST_END_DIGIT:   cfg_q.test_end_digit   <= cfg_wr.data[3:0];
				CFG_BLANK_CODE:       cfg_q.blank_code       <= cfg_wr.data[7:0];
				CFG_ZERO_CODE:        cfg_q.zero_code        <= cfg_wr.data[7:0];
				CFG_TEST_PERIOD:      cfg_q.test_period      <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/sss_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_core: segment buffer, scan pointer, self-test walk and drive latch
// Computes the next state for one transaction and registers it.
// ----------------------------------------------------------------------------
module sss_core #(
	parameter int DIGITS       = 8,
	parameter int FONT_ENTRIES = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic [2:0]       opcode,
	input  logic [2:0]       digit_index,
	input  logic [7:0]       char_code,
	input  sss_pkg::cfg_t    cfg,
	input  sss_pkg::cfg_wr_t cfg_wr,
	output sss_pkg::result_t result
);
	import sss_pkg::*;

	localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [7:0]    seg_buf_q [DIGITS];
	logic [7:0]    seg_buf_n [DIGITS];
	logic [DW-1:0] scan_q, scan_n;
	logic [2:0]    tdc_q, tdc_n;
	logic [3:0]    step_q, step_n;
	logic          shown_q, shown_n;
	logic [15:0]   period_q, period_n;
	logic [7:0]    lines_q, lines_n;
	logic [7:0]    segs_q, segs_n;
	logic          bad_n;

	logic          wr_en;
	logic [2:0]    wr_addr;
	logic [7:0]    wr_data;
	logic          clr_all;
	logic [15:0]   period_inc;
	logic [3:0]    step_inc;
	logic [3:0]    step_limit;
	logic [3:0]    end_digit;
	logic [3:0]    tdc_inc;
	logic [7:0]    pattern;
	logic [7:0]    scan_bit;

	always_comb begin
		period_inc = period_q + 16'd1;
		step_inc   = step_q + 4'd1;
		step_limit = cfg.test_kind ? WALK_LAST_STEP : FONT_LAST_STEP;
		end_digit  = (cfg.test_end_digit > 4'(DIGITS)) ? 4'(DIGITS) : cfg.test_end_digit;
		tdc_inc    = {1'b0, tdc_q} + 4'd1;
		pattern    = cfg.test_kind ? (WALK_TOP >> step_q) : font_lookup({2'b00, step_q});
		scan_bit   = 8'd1 << scan_q;

		scan_n   = scan_q;
		tdc_n    = tdc_q;
		step_n   = step_q;
		shown_n  = shown_q;
		period_n = period_q;
		lines_n  = lines_q;
		segs_n   = segs_q;
		bad_n    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = digit_index;
		wr_data  = char_code;
		clr_all  = 1'b0;

		if (cfg_wr.valid && cfg_wr.index == CFG_TEST_ENABLE) begin
			// enable edges act on the walk position at once
			if (cfg_wr.data[0] && !cfg.test_enable) begin
				tdc_n = cfg.test_first_digit;
			end else if (!cfg_wr.data[0] && cfg.test_enable) begin
				tdc_n  = 3'd0;
				step_n = 4'd0;
			end
		end else if (in_fire) begin
			case (opcode)
				OP_WRITE_CHAR: begin
					wr_en = 1'b1;
					if (char_code < 8'(FONT_ENTRIES)) begin
						wr_data = font_lookup(char_code[5:0]);
					end else begin
						bad_n   = 1'b1;
						wr_data = cfg.blank_code;
					end
				end
				OP_WRITE_RAW: begin
					wr_en = 1'b1;
				end
				OP_CLEAR: begin
					clr_all = 1'b1;
				end
				OP_SCAN: begin
					lines_n = cfg.active_level ? scan_bit : ~scan_bit;
					segs_n  = seg_buf_q[scan_q];
					scan_n  = (scan_q == DW'(DIGITS - 1)) ? '0 : scan_q + 1'b1;
				end
				OP_TIME: begin
					wr_addr = tdc_q;
					if (!shown_q) begin
						if (cfg.test_enable) begin
							wr_en    = 1'b1;
							wr_data  = pattern;
							period_n = 16'd0;
							shown_n  = 1'b1;
						end
					end else begin
						period_n = period_inc;
						if (period_inc >= cfg.test_period) begin
							period_n = 16'd0;
							step_n   = step_inc;
							if (step_inc > step_limit) begin
								// leave the digit settled and move on
								wr_en   = 1'b1;
								wr_data = cfg.test_kind ? cfg.blank_code : cfg.zero_code;
								step_n  = 4'd0;
								if (tdc_inc >= end_digit) begin
									tdc_n   = cfg.test_first_digit;
									clr_all = 1'b1;
								end else begin
									tdc_n = tdc_q + 3'd1;
								end
							end
							shown_n = 1'b0;
						end
						if (!cfg.test_enable) begin
							tdc_n    = 3'd0;
							step_n   = 4'd0;
							shown_n  = 1'b0;
							period_n = 16'd0;
							clr_all  = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end

		for (int i = 0; i < DIGITS; i++) begin
			if (clr_all) begin
				seg_buf_n[i] = cfg.blank_code;
			end else if (wr_en && wr_addr == 3'(i)) begin
				seg_buf_n[i] = wr_data;
			end else begin
				seg_buf_n[i] = seg_buf_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				seg_buf_q[i] <= 8'd0;
			end
			scan_q   <= '0;
			tdc_q    <= 3'd0;
			step_q   <= 4'd0;
			shown_q  <= 1'b0;
			period_q <= 16'd0;
			lines_q  <= LINES_IDLE;
			segs_q   <= 8'd0;
		end else begin
			for (int i = 0; i < DIGITS; i++) begin
				seg_buf_q[i] <= seg_buf_n[i];
			end
			scan_q   <= scan_n;
			tdc_q    <= tdc_n;
			step_q   <= step_n;
			shown_q  <= shown_n;
			period_q <= period_n;
			lines_q  <= lines_n;
			segs_q   <= segs_n;
		end
	end

	assign result.digit_lines = lines_n;
	assign result.segments    = segs_n;
	assign result.bad_code    = bad_n;
	assign result.test_digit  = tdc_n;

endmodule

@@ tb/seven_segment_scan_with_test_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_with_test_tb: self-checking bench for the scan driver
// Drives command transactions into the display driver and writes its
// registers between phases. A shadow copy of the segment buffer, the scan
// position, the self-test walk and the drive latch predicts every result
// transaction, which is then compared field by field as it drains out.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_test_tb;
	import sss_pkg::*;

	localparam int SLOTS       = 8;
	localparam int GLYPH_COUNT = 37;
	localparam int STALL_LIMIT = 2000;

	// opcodes above OP_TIME do nothing but repeat the drive latch
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_MID   = 3'd6;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	// character glyphs, entry 0 in the low byte
	localparam logic [36:0][7:0] GLYPHS = {
		8'h08, 8'h49, 8'h3B, 8'h36, 8'h2B, 8'h1C, 8'h3E,
		8'h0F, 8'h1B, 8'h05, 8'h73, 8'h67, 8'h1D, 8'h15, 8'h76, 8'h0E, 8'h2F,
		8'h38, 8'h10, 8'h17, 8'h5E, 8'h47, 8'h4F, 8'h3D, 8'h4E, 8'h1F, 8'h77,
		8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E
	};

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode      = OP_WRITE_CHAR;
	logic [2:0]  digit_index = 3'd0;
	logic [7:0]  char_code   = 8'd0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  digit_lines;
	logic [7:0]  segments;
	logic        bad_code;
	logic [2:0]  test_digit;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index   = CFG_ACTIVE_LEVEL;
	logic [15:0] cfg_data    = 16'd0;

	seven_segment_scan_with_test uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.digit_index (digit_index),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digit_lines (digit_lines),
		.segments    (segments),
		.bad_code    (bad_code),
		.test_digit  (test_digit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// shadow of the block: registers, buffer, scan position, test walk, latch
	cfg_t        regs;
	logic [7:0]  shadow_buf [SLOTS];
	logic [2:0]  scan_pos;
	logic [2:0]  walk_digit;
	logic [3:0]  walk_step;
	logic        pattern_on;
	logic [15:0] dwell_count;
	logic [7:0]  latch_lines;
	logic [7:0]  latch_segs;

	// predicted drive results, oldest first
	result_t pending_drives [$];
	int      errors      = 0;
	int      burst_left  = 0;
	int      ready_hold  = 0;
	int      idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] glyph(input int idx);
		return (idx < GLYPH_COUNT) ? GLYPHS[idx] : 8'h00;
	endfunction

	function automatic void fill_buffer(input logic [7:0] val);
		for (int i = 0; i < SLOTS; i++)
			shadow_buf[i] = val;
	endfunction

	function automatic void reset_shadow();
		regs = '0;
		regs.test_end_digit = RST_END_DIGIT;
		regs.zero_code = RST_ZERO_CODE;
		regs.test_period = RST_PERIOD;
		fill_buffer(8'h00);
		scan_pos = '0;
		walk_digit = '0;
		walk_step = '0;
		pattern_on = 1'b0;
		dwell_count = '0;
		latch_lines = LINES_IDLE;
		latch_segs = 8'h00;
	endfunction

	// Mirror a register write, including the enable edge effects on the walk.
	function automatic void apply_register(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			CFG_ACTIVE_LEVEL: regs.active_level = data[0];
			CFG_TEST_ENABLE: begin
				if (data[0] && !regs.test_enable) begin
					walk_digit = regs.test_first_digit;
				end else if (!data[0] && regs.test_enable) begin
					walk_digit = '0;
					walk_step = '0;
				end
				regs.test_enable = data[0];
			end
			CFG_TEST_KIND:        regs.test_kind = data[0];
			CFG_TEST_FIRST_DIGIT: regs.test_first_digit = data[2:0];
			CFG_TEST_END_DIGIT:   regs.test_end_digit = data[3:0];
			CFG_BLANK_CODE:       regs.blank_code = data[7:0];
			CFG_ZERO_CODE:        regs.zero_code = data[7:0];
			CFG_TEST_PERIOD:      regs.test_period = data;
			default: ;
		endcase
	endfunction

	// One time tick of the self-test walk.
	function automatic void advance_walk();
		int last_step;
		int wrap_at;
		// show the pattern of the current step and start its dwell
		if (!pattern_on) begin
			if (regs.test_enable) begin
				shadow_buf[walk_digit] = regs.test_kind ? (WALK_TOP >> walk_step)
				                                        : glyph(walk_step);
				dwell_count = '0;
				pattern_on = 1'b1;
			end
			return;
		end
		dwell_count = dwell_count + 16'd1;
		// a zero period compares as reached on every tick
		if (dwell_count >= regs.test_period) begin
			last_step = regs.test_kind ? int'(WALK_LAST_STEP) : int'(FONT_LAST_STEP);
			dwell_count = '0;
			walk_step = walk_step + 4'd1;
			if (walk_step > last_step) begin
				// end digit above the digit count acts as the digit count
				wrap_at = (regs.test_end_digit > SLOTS) ? SLOTS : int'(regs.test_end_digit);
				shadow_buf[walk_digit] = regs.test_kind ? regs.blank_code : regs.zero_code;
				walk_step = '0;
				if (int'(walk_digit) + 1 >= wrap_at) begin
					walk_digit = regs.test_first_digit;
					fill_buffer(regs.blank_code);
				end else begin
					walk_digit = walk_digit + 3'd1;
				end
			end
			pattern_on = 1'b0;
		end
		// a test disabled while a pattern is shown drops the walk and the buffer
		if (!regs.test_enable) begin
			walk_digit = '0;
			walk_step = '0;
			pattern_on = 1'b0;
			dwell_count = '0;
			fill_buffer(regs.blank_code);
		end
	endfunction

	// Apply one command to the shadow and return the drive it must produce.
	function automatic result_t apply_command(input logic [2:0] op, input logic [2:0] d,
	                                          input logic [7:0] c);
		result_t    r;
		logic [7:0] sel;
		r.bad_code = 1'b0;
		case (op)
			OP_WRITE_CHAR: begin
				if (c < GLYPH_COUNT) begin
					shadow_buf[d] = glyph(c);
				end else begin
					r.bad_code = 1'b1;
					shadow_buf[d] = regs.blank_code;
				end
			end
			OP_WRITE_RAW: shadow_buf[d] = c;
			OP_CLEAR:     fill_buffer(regs.blank_code);
			OP_SCAN: begin
				sel = 8'd1 << scan_pos;
				latch_lines = regs.active_level ? sel : ~sel;
				latch_segs = shadow_buf[scan_pos];
				scan_pos = scan_pos + 3'd1;
			end
			OP_TIME: advance_walk();
			default: ;
		endcase
		r.digit_lines = latch_lines;
		r.segments = latch_segs;
		r.test_digit = walk_digit;
		return r;
	endfunction

	// Send one command transaction; a used-up burst starts anew, mostly after an idle gap.
	task automatic send_command(input logic [2:0] op, input logic [2:0] d,
	                            input logic [7:0] c);
		int gap;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		digit_index <= d;
		char_code <= c;
		// hold the transaction until the block takes it
		do @(posedge clk); while (!(in_valid && in_ready));
		pending_drives.push_back(apply_command(op, d, c));
	endtask

	// Write one register; valid stays up so back-to-back writes need no gap.
	task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		apply_register(idx, data);
	endtask

	// Stop sending and wait until every predicted drive has come out.
	task automatic settle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		burst_left = 0;
	endtask

	// Random commands with the given share of time ticks and scan ticks.
	task automatic run_traffic(input int count, input int time_pct, input int scan_pct);
		int         roll;
		logic [2:0] op;
		logic [7:0] code;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < time_pct) begin
				op = OP_TIME;
			end else if (roll < time_pct + scan_pct) begin
				op = OP_SCAN;
			end else begin
				case ($urandom_range(0, 9))
					0:          op = OP_CLEAR;
					1:          op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
					2, 3, 4, 5: op = OP_WRITE_CHAR;
					default:    op = OP_WRITE_RAW;
				endcase
			end
			// mostly codes within the font or just past its end, sometimes any byte
			code = ($urandom_range(0, 3) == 0) ? 8'($urandom)
			                                   : 8'($urandom_range(0, GLYPH_COUNT + 3));
			send_command(op, 3'($urandom_range(0, SLOTS - 1)), code);
		end
	endtask

	// Latch right after reset: lines inactive, segments zero, no test running.
	task automatic test_reset_latch();
		send_command(OP_SPARE_FIRST, 3'd7, 8'hFF);
		send_command(OP_TIME, 3'd0, 8'h00);
		send_command(OP_SPARE_LAST, 3'd0, 8'h00);
		send_command(OP_SPARE_MID, 3'd3, 8'h5A);
	endtask

	// Font hits, both font ends, bad codes and raw bytes, then read all back.
	task automatic test_buffer_writes();
		send_command(OP_WRITE_CHAR, 3'd0, 8'd0);
		send_command(OP_WRITE_CHAR, 3'd1, 8'd36);
		send_command(OP_WRITE_CHAR, 3'd2, 8'd37);
		send_command(OP_WRITE_CHAR, 3'd3, 8'd255);
		send_command(OP_WRITE_RAW, 3'd4, 8'hFF);
		send_command(OP_WRITE_RAW, 3'd5, 8'h00);
		send_command(OP_WRITE_RAW, 3'd6, 8'hAA);
		send_command(OP_WRITE_RAW, 3'd7, 8'h55);
		repeat (SLOTS)
			send_command(OP_SCAN, 3'd0, 8'h00);
	endtask

	// Active-high digit lines and a non-zero blank byte on clear and bad codes.
	task automatic test_scan_levels();
		settle();
		write_register(CFG_ACTIVE_LEVEL, 16'd1);
		write_register(CFG_BLANK_CODE, 16'h00FF);
		send_command(OP_WRITE_CHAR, 3'd2, 8'd37);
		repeat (3)
			send_command(OP_SCAN, 3'd0, 8'h00);
		send_command(OP_CLEAR, 3'd0, 8'h00);
		send_command(OP_SCAN, 3'd0, 8'h00);
		// the latch keeps its levels until the next scan
		settle();
		write_register(CFG_ACTIVE_LEVEL, 16'd0);
		send_command(OP_SPARE_FIRST, 3'd0, 8'h00);
		send_command(OP_SCAN, 3'd0, 8'h00);
	endtask

	// Font walk over the last two digits with a period of 1, then disable.
	task automatic test_font_walk();
		settle();
		write_register(CFG_TEST_PERIOD, 16'd1);
		write_register(CFG_TEST_FIRST_DIGIT, 16'd6);
		write_register(CFG_TEST_END_DIGIT, 16'd8);
		write_register(CFG_TEST_KIND, 16'd0);
		write_register(CFG_ZERO_CODE, 16'h0000);
		write_register(CFG_TEST_ENABLE, 16'd1);
		run_traffic(70, 65, 30);
		settle();
		write_register(CFG_TEST_ENABLE, 16'd0);
		run_traffic(10, 60, 35);
	endtask

	// Walking segment bit, zero period, end digit zero wrapping after every digit.
	task automatic test_segment_walk();
		settle();
		write_register(CFG_TEST_KIND, 16'd1);
		write_register(CFG_TEST_PERIOD, 16'd0);
		write_register(CFG_TEST_FIRST_DIGIT, 16'd3);
		write_register(CFG_TEST_END_DIGIT, 16'd0);
		write_register(CFG_BLANK_CODE, 16'h0000);
		write_register(CFG_TEST_ENABLE, 16'd1);
		run_traffic(50, 70, 25);
	endtask

	// End digit past the count, kind switched mid-digit, longest period, end at 1.
	task automatic test_walk_limits();
		settle();
		write_register(CFG_TEST_END_DIGIT, 16'd15);
		write_register(CFG_TEST_FIRST_DIGIT, 16'd7);
		write_register(CFG_TEST_PERIOD, 16'd2);
		write_register(CFG_TEST_KIND, 16'd0);
		write_register(CFG_ZERO_CODE, 16'h00FF);
		run_traffic(40, 70, 20);
		settle();
		write_register(CFG_TEST_KIND, 16'd1);
		run_traffic(30, 70, 20);
		settle();
		write_register(CFG_TEST_PERIOD, 16'hFFFF);
		run_traffic(10, 80, 10);
		settle();
		write_register(CFG_TEST_FIRST_DIGIT, 16'd0);
		write_register(CFG_TEST_END_DIGIT, 16'd1);
		write_register(CFG_TEST_PERIOD, 16'd1);
		run_traffic(30, 70, 20);
		settle();
		write_register(CFG_TEST_ENABLE, 16'd0);
		run_traffic(10, 60, 30);
	endtask

	// Random register settings per phase, each followed by random commands.
	task automatic test_random_mix();
		logic [2:0]  reg_idx;
		logic [15:0] val;
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			for (int i = 0; i < 8; i++) begin
				reg_idx = 3'(i);
				case (reg_idx)
					CFG_TEST_FIRST_DIGIT:        val = 16'($urandom_range(0, 7));
					CFG_TEST_END_DIGIT:          val = 16'($urandom_range(0, 15));
					CFG_BLANK_CODE, CFG_ZERO_CODE: val = 16'($urandom_range(0, 255));
					CFG_TEST_PERIOD: begin
						// keep most periods short so the walk gets somewhere
						case ($urandom_range(0, 5))
							0:       val = 16'hFFFF;
							1:       val = 16'($urandom);
							default: val = 16'($urandom_range(0, 3));
						endcase
					end
					default: val = 16'($urandom_range(0, 1));
				endcase
				if ($urandom_range(0, 1) == 1)
					write_register(reg_idx, val);
			end
			run_traffic($urandom_range(25, 45), $urandom_range(35, 65), 25);
		end
	endtask

	// Receiver: long ready stretches, random stalls, and toggling.
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					out_ready <= 1'b0;
					ready_hold <= $urandom_range(0, 11);
				end
				1: begin
					out_ready <= 1'b1;
					ready_hold <= $urandom_range(10, 40);
				end
				default: begin
					out_ready <= 1'($urandom_range(0, 1));
					ready_hold <= 0;
				end
			endcase
		end
	end

	// Compare each drained result against the oldest prediction.
	always @(posedge clk) begin : check_drive
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drives.size() == 0) begin
				$error("result transaction with none pending: lines %h segments %h",
				       digit_lines, segments);
				errors++;
			end else begin
				want = pending_drives.pop_front();
				if (digit_lines !== want.digit_lines) begin
					$error("digit_lines: expected %h, got %h", want.digit_lines, digit_lines);
					errors++;
				end
				if (segments !== want.segments) begin
					$error("segments: expected %h, got %h", want.segments, segments);
					errors++;
				end
				if (bad_code !== want.bad_code) begin
					$error("bad_code: expected %b, got %b", want.bad_code, bad_code);
					errors++;
				end
				if (test_digit !== want.test_digit) begin
					$error("test_digit: expected %0d, got %0d", want.test_digit, test_digit);
					errors++;
				end
			end
		end
	end

	// Watchdog: drop the run when no channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
		    || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_shadow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_latch();
		test_buffer_writes();
		test_scan_levels();
		test_font_walk();
		test_segment_walk();
		test_walk_limits();
		test_random_mix();
		// drain what is still in flight before the verdict
		settle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ seven_segment_scan_with_test.f @@
sv/sss_pkg.sv
sv/sss_regs.sv
sv/sss_core.sv
sv/seven_segment_scan_with_test.sv
tb/seven_segment_scan_with_test_tb.sv
